// ===== rtl/vtpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpp_pkg
// Shared types, codes and saturation helper for the vertex transform and
// perspective projection pipeline.
// ----------------------------------------------------------------------------
package vtpp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_COEFS     = 12;
  localparam int COEF_W        = 32;
  localparam int SIZE_W        = 14;
  localparam int CFG_IDX_W     = 2;

  // Item kinds carried on the input tuser.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
  localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } sat32_t;

  // Viewer-space vertex with its running saturation flag.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } view_t;

  // Sideband that travels alongside the divider lanes.
  typedef struct packed {
    logic sgn_y;
    logic sgn_z;
    logic sat;
  } side_t;

  function automatic sat32_t sat32(input logic signed [67:0] v);
    sat32_t r;
    if (v > SAT_MAX) begin
      r.value = 32'sh7FFFFFFF;
      r.sat   = 1'b1;
    end else if (v < SAT_MIN) begin
      r.value = 32'sh80000000;
      r.sat   = 1'b1;
    end else begin
      r.value = v[31:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/vtpp_xform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpp_xform
// Three-stage rigid transform: products, rounded sums, translation and clip.
// ----------------------------------------------------------------------------
module vtpp_xform #(
  parameter int FRAC_BITS = vtpp_pkg::FRAC_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             in_valid,
  output logic                                             in_adv,
  input  logic [vtpp_pkg::NUM_COEFS-1:0][vtpp_pkg::COEF_W-1:0] coefs,
  input  logic signed [31:0]                               in_x,
  input  logic signed [31:0]                               in_y,
  input  logic signed [31:0]                               in_z,
  output logic                                             out_valid,
  input  logic                                             out_adv,
  output vtpp_pkg::view_t                                  out_view
);

  localparam logic signed [65:0] RND = 66'sd1 <<< (FRAC_BITS - 1);

  logic v1, v2, v3;
  logic adv1, adv2, adv3;
  logic signed [31:0] vin [3];
  logic signed [63:0] p1 [9];
  logic signed [31:0] t1 [3];
  logic signed [31:0] t2 [3];
  logic signed [65:0] s2 [3];
  vtpp_pkg::sat32_t   c3 [3];
  vtpp_pkg::view_t    r3;
  vtpp_pkg::view_t    r3_next;

  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;

  assign adv3   = !v3 || out_adv;
  assign adv2   = !v2 || adv3;
  assign adv1   = !v1 || adv2;
  assign in_adv = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Exact sum of three products plus half an LSB, then floor shift:
  // this is round to nearest with ties toward plus infinity.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      c3[r] = vtpp_pkg::sat32(68'(s2[r] >>> FRAC_BITS) + 68'(t2[r]));
    end
    r3_next.x   = c3[0].value;
    r3_next.y   = c3[1].value;
    r3_next.z   = c3[2].value;
    r3_next.sat = c3[0].sat | c3[1].sat | c3[2].sat;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p1[r*3+c] <= $signed(coefs[r*3+c]) * vin[c];
        end
        t1[r] <= $signed(coefs[vtpp_pkg::NUM_COEFS-3+r]);
      end
    end
    if (adv2) begin
      for (int r = 0; r < 3; r++) begin
        s2[r] <= 66'(p1[r*3]) + 66'(p1[r*3+1]) + 66'(p1[r*3+2]) + RND;
        t2[r] <= t1[r];
      end
    end
    if (adv3) r3 <= r3_next;
  end

  assign out_valid = v3;
  assign out_view  = r3;

endmodule

// ===== rtl/vtpp_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpp_scale
// Depth clamp, magnitude and sign split, focal scaling and rounding bias.
// ----------------------------------------------------------------------------
module vtpp_scale #(
  parameter int FRAC_BITS = vtpp_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_adv,
  input  vtpp_pkg::view_t in_view,
  input  logic [31:0]     focal,
  output logic            out_valid,
  input  logic            out_adv,
  output logic [63:0]     out_num_y,
  output logic [63:0]     out_num_z,
  output logic [30:0]     out_den,
  output vtpp_pkg::side_t out_side
);

  localparam logic signed [31:0] DEPTH_MIN = 32'(((1 << FRAC_BITS) + 5) / 10);

  logic v1, v2, v3;
  logic adv1, adv2, adv3;
  logic [30:0] dep1, dep2, dep3;
  logic [31:0] mag_y1, mag_z1;
  logic [63:0] prod_y2, prod_z2;
  logic [63:0] num_y3, num_z3;
  vtpp_pkg::side_t side1, side2, side3;

  assign adv3   = !v3 || out_adv;
  assign adv2   = !v2 || adv3;
  assign adv1   = !v1 || adv2;
  assign in_adv = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // The vertical coordinate is projected from -z, so its sign is that of -z.
  always_ff @(posedge clk) begin
    if (adv1) begin
      dep1        <= (in_view.x < DEPTH_MIN) ? DEPTH_MIN[30:0] : in_view.x[30:0];
      mag_y1      <= in_view.y[31] ? 32'(-in_view.y) : in_view.y;
      mag_z1      <= in_view.z[31] ? 32'(-in_view.z) : in_view.z;
      side1.sgn_y <= in_view.y[31];
      side1.sgn_z <= !in_view.z[31] && (in_view.z != 32'sd0);
      side1.sat   <= in_view.sat;
    end
    if (adv2) begin
      prod_y2 <= 64'(mag_y1) * 64'(focal);
      prod_z2 <= 64'(mag_z1) * 64'(focal);
      dep2    <= dep1;
      side2   <= side1;
    end
    if (adv3) begin
      num_y3 <= prod_y2 + 64'(dep2 >> 1);
      num_z3 <= prod_z2 + 64'(dep2 >> 1);
      dep3   <= dep2;
      side3  <= side2;
    end
  end

  assign out_valid = v3;
  assign out_num_y = num_y3;
  assign out_num_z = num_z3;
  assign out_den   = dep3;
  assign out_side  = side3;

endmodule

// ===== rtl/vtpp_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpp_divider
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vtpp_divider #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 31,
  parameter int SIDE_W = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_adv,
  input  logic [NUM_W-1:0]  in_num_a,
  input  logic [NUM_W-1:0]  in_num_b,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_adv,
  output logic [NUM_W-1:0]  out_q_a,
  output logic [NUM_W-1:0]  out_q_b,
  output logic [SIDE_W-1:0] out_side
);

  logic [NUM_W-1:0]  vld;
  logic [NUM_W-1:0]  adv;
  logic [DEN_W-1:0]  rem_a [NUM_W];
  logic [DEN_W-1:0]  rem_b [NUM_W];
  logic [NUM_W-1:0]  nq_a  [NUM_W];
  logic [NUM_W-1:0]  nq_b  [NUM_W];
  logic [DEN_W-1:0]  den   [NUM_W];
  logic [SIDE_W-1:0] side  [NUM_W];

  // One restoring step: the next numerator bit enters the remainder and the
  // quotient bit shifts in at the bottom of the numerator word.
  function automatic logic [DEN_W+NUM_W-1:0] div_step(
    input logic [DEN_W-1:0] rem,
    input logic [NUM_W-1:0] nq,
    input logic [DEN_W-1:0] d
  );
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;
    trial = {rem, nq[NUM_W-1]};
    diff  = trial - {1'b0, d};
    ge    = trial >= {1'b0, d};
    return {(ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0]), nq[NUM_W-2:0], ge};
  endfunction

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic              vin;
    logic [DEN_W-1:0]  rin_a, rin_b, din;
    logic [NUM_W-1:0]  qin_a, qin_b;
    logic [SIDE_W-1:0] sin;

    if (k == 0) begin : g_first
      assign vin   = in_valid;
      assign rin_a = '0;
      assign rin_b = '0;
      assign qin_a = in_num_a;
      assign qin_b = in_num_b;
      assign din   = in_den;
      assign sin   = in_side;
    end else begin : g_next
      assign vin   = vld[k-1];
      assign rin_a = rem_a[k-1];
      assign rin_b = rem_b[k-1];
      assign qin_a = nq_a[k-1];
      assign qin_b = nq_b[k-1];
      assign din   = den[k-1];
      assign sin   = side[k-1];
    end

    if (k == NUM_W - 1) begin : g_last
      assign adv[k] = !vld[k] || out_adv;
    end else begin : g_mid
      assign adv[k] = !vld[k] || adv[k+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv[k]) begin
        vld[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        {rem_a[k], nq_a[k]} <= div_step(rin_a, qin_a, din);
        {rem_b[k], nq_b[k]} <= div_step(rin_b, qin_b, din);
        den[k]              <= din;
        side[k]             <= sin;
      end
    end
  end

  assign in_adv    = adv[0];
  assign out_valid = vld[NUM_W-1];
  assign out_q_a   = nq_a[NUM_W-1];
  assign out_q_b   = nq_b[NUM_W-1];
  assign out_side  = side[NUM_W-1];

endmodule

// ===== rtl/vertex_transform_perspective_project.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_perspective_project
// Rigid transform of vertices into viewer space and perspective projection.
// ----------------------------------------------------------------------------
// A vertex beat is accepted every clock cycle while the output side keeps
// taking results, and its result beat passes in order through three stages
// of transform (nine 32x32 products, rounded sums, translation with clip),
// three stages of depth clamp and focal scaling, 64 stages of a restoring
// divider that retires one quotient bit per stage for both screen axes, and
// the output register that adds half the screen size and saturates. Each
// stage stalls only when its successor is full, so bubbles close up and
// input is taken while a result waits. Coefficient load beats (tuser low)
// update the transform at once, give no result beat, and apply to every
// vertex accepted after them.
module vertex_transform_perspective_project #(
  parameter int FRAC_BITS = vtpp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // From bit 0: coef_index[3:0], coef_value[35:4], vertex_x[67:36],
  // vertex_y[99:68], vertex_z[131:100], zero padding [135:132].
  input  logic [135:0]                   s_tdata,
  // opcode: 0 loads a coefficient, 1 transforms a vertex.
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // From bit 0: screen_x[31:0], screen_y[63:32].
  output logic [63:0]                    m_tdata,
  // saturated.
  output logic                           m_tuser,
  input  logic                           cfg_we,
  input  logic [vtpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  logic [vtpp_pkg::NUM_COEFS-1:0][vtpp_pkg::COEF_W-1:0] coefs;
  logic [31:0]                 focal;
  logic [vtpp_pkg::SIZE_W-1:0] screen_width;
  logic [vtpp_pkg::SIZE_W-1:0] screen_height;

  logic [3:0]         coef_index;
  logic signed [31:0] coef_value, vertex_x, vertex_y, vertex_z;
  logic               load_beat;

  assign coef_index = s_tdata[3:0];
  assign coef_value = s_tdata[35:4];
  assign vertex_x   = s_tdata[67:36];
  assign vertex_y   = s_tdata[99:68];
  assign vertex_z   = s_tdata[131:100];
  assign load_beat  = s_tvalid && s_tready && (s_tuser == vtpp_pkg::OP_LOAD);

  // Transform coefficients reset to identity rotation and zero translation.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vtpp_pkg::NUM_COEFS; i++) begin
        coefs[i] <= (i == 0 || i == 4 || i == 8) ? ONE : '0;
      end
    end else if (load_beat && (coef_index < 4'(vtpp_pkg::NUM_COEFS))) begin
      coefs[coef_index] <= coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      focal         <= ONE;
      screen_width  <= 14'd640;
      screen_height <= 14'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        vtpp_pkg::CFG_FOCAL:  focal         <= cfg_data;
        vtpp_pkg::CFG_WIDTH:  screen_width  <= cfg_data[vtpp_pkg::SIZE_W-1:0];
        vtpp_pkg::CFG_HEIGHT: screen_height <= cfg_data[vtpp_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline interconnect.
  logic            xf_adv, xf_valid, sc_adv, sc_valid, dv_adv, dv_valid, out_adv;
  vtpp_pkg::view_t xf_view;
  logic [63:0]     sc_num_y, sc_num_z, q_y, q_z;
  logic [30:0]     sc_den;
  vtpp_pkg::side_t sc_side, dv_side;

  assign s_tready = xf_adv;

  vtpp_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid && (s_tuser == vtpp_pkg::OP_VERTEX)),
    .in_adv    (xf_adv),
    .coefs     (coefs),
    .in_x      (vertex_x),
    .in_y      (vertex_y),
    .in_z      (vertex_z),
    .out_valid (xf_valid),
    .out_adv   (sc_adv),
    .out_view  (xf_view)
  );

  vtpp_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (xf_valid),
    .in_adv    (sc_adv),
    .in_view   (xf_view),
    .focal     (focal),
    .out_valid (sc_valid),
    .out_adv   (dv_adv),
    .out_num_y (sc_num_y),
    .out_num_z (sc_num_z),
    .out_den   (sc_den),
    .out_side  (sc_side)
  );

  vtpp_divider #(
    .NUM_W  (64),
    .DEN_W  (31),
    .SIDE_W ($bits(vtpp_pkg::side_t))
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sc_valid),
    .in_adv    (dv_adv),
    .in_num_a  (sc_num_y),
    .in_num_b  (sc_num_z),
    .in_den    (sc_den),
    .in_side   (sc_side),
    .out_valid (dv_valid),
    .out_adv   (out_adv),
    .out_q_a   (q_y),
    .out_q_b   (q_z),
    .out_side  (dv_side)
  );

  // Output stage: apply the sign, add half the screen size, saturate.
  logic               out_valid;
  logic signed [65:0] half_x, half_y, sum_x, sum_y, qs_y, qs_z;
  vtpp_pkg::sat32_t   sat_x, sat_y;
  logic [63:0]        out_data;
  logic               out_sat;

  assign out_adv = !out_valid || m_tready;

  always_comb begin
    half_x = $signed(66'(screen_width) << (FRAC_BITS - 1));
    half_y = $signed(66'(screen_height) << (FRAC_BITS - 1));
    qs_y   = $signed({2'b00, q_y});
    qs_z   = $signed({2'b00, q_z});
    sum_x  = (dv_side.sgn_y ? -qs_y : qs_y) + half_x;
    sum_y  = (dv_side.sgn_z ? -qs_z : qs_z) + half_y;
    sat_x  = vtpp_pkg::sat32(68'(sum_x));
    sat_y  = vtpp_pkg::sat32(68'(sum_y));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_data <= {sat_y.value, sat_x.value};
      out_sat  <= dv_side.sat | sat_x.sat | sat_y.sat;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_sat;

`ifndef SYNTHESIS
  // With the last stage empty every stage can advance, so input is open.
  a_empty_open: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output stage");

  a_bad_index: assert property (@(posedge clk) disable iff (rst)
    load_beat && (coef_index >= 4'(vtpp_pkg::NUM_COEFS)) |=> $stable(coefs))
    else $error("out-of-range coefficient load changed the transform");

  a_focal_write: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == vtpp_pkg::CFG_FOCAL) |=> focal == $past(cfg_data))
    else $error("focal length write lost");

  a_reset_identity: assert property (@(posedge clk)
    rst |=> (coefs[0] == ONE) && (coefs[4] == ONE) && (coefs[8] == ONE))
    else $error("transform not identity after reset");
`endif

endmodule
